// ----- hdl/kpra_pkg.sv -----
// Package with shared types, codes and constants of the keypad press repeat block.
package kpra_pkg;

   localparam int KEY_BITS   = 6;
   localparam int CODE_W     = 6;
   localparam int TICK_W     = 32;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 3;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [CODE_W-1:0]   code_type;
   typedef logic [TICK_W-1:0]   tick_type;
   typedef logic [CFG_W-1:0]    cfg_word_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_SHORT = 2'd1,
      KIND_LONG  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RELEASE_LOCKOUT = 3'd0,
      CSR_HOLD_BEFORE_REP = 3'd1,
      CSR_REP_START       = 3'd2,
      CSR_REP_FLOOR       = 3'd3,
      CSR_SPEEDUP_PERIOD  = 3'd4,
      CSR_SPEEDUP_AMOUNT  = 3'd5
   } csr_idx_type;

   localparam cfg_word_type RST_RELEASE_LOCKOUT = 16'd200;
   localparam cfg_word_type RST_HOLD_BEFORE_REP = 16'd500;
   localparam cfg_word_type RST_REP_START       = 16'd200;
   localparam cfg_word_type RST_REP_FLOOR       = 16'd50;
   localparam cfg_word_type RST_SPEEDUP_PERIOD  = 16'd500;
   localparam cfg_word_type RST_SPEEDUP_AMOUNT  = 16'd25;

   typedef struct packed {
      cfg_word_type release_lockout;
      cfg_word_type hold_before_repeat;
      cfg_word_type repeat_start_interval;
      cfg_word_type repeat_floor_interval;
      cfg_word_type speedup_period;
      cfg_word_type speedup_amount;
   } cfg_type;

   typedef struct packed {
      code_type key_code;
      kind_type press_kind;
   } result_type;

   // Keeps only the scanned bits that exist, then drops scans with several keys.
   function automatic key_type single_key(input code_type bits);
      key_type c;
      for (int i = 0; i < KEY_BITS; i++) begin
         c[i] = (i < CODE_W) ? bits[i % CODE_W] : 1'b0;
      end
      if ((c & (c - key_type'(1))) != '0) begin
         c = '0;
      end
      return c;
   endfunction

   function automatic code_type key_to_code(input key_type k);
      code_type c;
      for (int i = 0; i < CODE_W; i++) begin
         c[i] = (i < KEY_BITS) ? k[i % KEY_BITS] : 1'b0;
      end
      return c;
   endfunction

endpackage

// ----- hdl/kpra_req_if.sv -----
// Interface of the poll channel: valid, ready, tick count and scanned key bits.
interface kpra_req_if import kpra_pkg::*;;
   logic     valid;
   logic     ready;
   tick_type now_ticks;
   code_type key_bits;

   modport source (output valid, output now_ticks, output key_bits, input ready);
   modport sink   (input valid, input now_ticks, input key_bits, output ready);
endinterface

// ----- hdl/kpra_rsp_if.sv -----
// Interface of the result channel: valid, ready, reported key code and press kind.
interface kpra_rsp_if import kpra_pkg::*;;
   logic     valid;
   logic     ready;
   code_type key_code;
   kind_type press_kind;

   modport source (output valid, output key_code, output press_kind, input ready);
   modport sink   (input valid, input key_code, input press_kind, output ready);
endinterface

// ----- hdl/kpra_core.sv -----
// Press detection state and its per-poll decision logic.
module kpra_core import kpra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  tick_type   now_ticks,
   input  code_type   key_bits,
   input  cfg_type    cfg,
   output result_type result
);

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_PRESSED = 2'd1,
      MODE_REPEAT  = 2'd2
   } mode_type;

   mode_type     mode_ff, mode_in;
   key_type      held_code_ff, held_code_in;
   tick_type     press_stamp_ff, press_stamp_in;
   tick_type     repeat_stamp_ff, repeat_stamp_in;
   tick_type     release_stamp_ff, release_stamp_in;
   cfg_word_type repeat_interval_ff, repeat_interval_in;
   logic         lockout_pending_ff, lockout_pending_in;

   key_type  code;
   tick_type dt_press, dt_repeat, dt_release;

   always_comb begin
      code       = single_key(key_bits);
      dt_press   = now_ticks - press_stamp_ff;
      dt_repeat  = now_ticks - repeat_stamp_ff;
      dt_release = now_ticks - release_stamp_ff;

      mode_in            = mode_ff;
      held_code_in       = held_code_ff;
      press_stamp_in     = press_stamp_ff;
      repeat_stamp_in    = repeat_stamp_ff;
      release_stamp_in   = release_stamp_ff;
      repeat_interval_in = repeat_interval_ff;
      lockout_pending_in = lockout_pending_ff;
      result.key_code    = '0;
      result.press_kind  = KIND_NONE;

      unique case (mode_ff)
         MODE_PRESSED: begin
            if (code != held_code_ff) begin
               mode_in            = MODE_IDLE;
               release_stamp_in   = now_ticks;
               lockout_pending_in = 1'b1;
            end else if (dt_press >= tick_type'(cfg.hold_before_repeat)) begin
               press_stamp_in     = now_ticks;
               repeat_stamp_in    = now_ticks;
               repeat_interval_in = cfg.repeat_start_interval;
               mode_in            = MODE_REPEAT;
               result.key_code    = key_to_code(code);
               result.press_kind  = KIND_LONG;
            end
         end
         MODE_REPEAT: begin
            if (code != held_code_ff) begin
               mode_in = MODE_IDLE;
            end else if (dt_repeat >= tick_type'(repeat_interval_ff)) begin
               repeat_stamp_in   = now_ticks;
               result.key_code   = key_to_code(code);
               result.press_kind = KIND_LONG;
            end else if (repeat_interval_ff > cfg.repeat_floor_interval &&
                         dt_press >= tick_type'(cfg.speedup_period)) begin
               repeat_interval_in = (repeat_interval_ff > cfg.speedup_amount) ?
                                    repeat_interval_ff - cfg.speedup_amount : '0;
               press_stamp_in     = now_ticks;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (!(lockout_pending_ff &&
                  dt_release < tick_type'(cfg.release_lockout))) begin
               lockout_pending_in = 1'b0;
               if (code != '0) begin
                  mode_in           = MODE_PRESSED;
                  press_stamp_in    = now_ticks;
                  held_code_in      = code;
                  result.key_code   = key_to_code(code);
                  result.press_kind = KIND_SHORT;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_IDLE;
         held_code_ff       <= '0;
         press_stamp_ff     <= '0;
         repeat_stamp_ff    <= '0;
         release_stamp_ff   <= '0;
         repeat_interval_ff <= '0;
         lockout_pending_ff <= 1'b0;
      end else if (step) begin
         mode_ff            <= mode_in;
         held_code_ff       <= held_code_in;
         press_stamp_ff     <= press_stamp_in;
         repeat_stamp_ff    <= repeat_stamp_in;
         release_stamp_ff   <= release_stamp_in;
         repeat_interval_ff <= repeat_interval_in;
         lockout_pending_ff <= lockout_pending_in;
      end
   end

   a_report_onehot: assert property (@(posedge clock) disable iff (reset)
      step && result.press_kind != KIND_NONE |-> $onehot(result.key_code))
      else $error("Reported press carries a key code that is not one-hot.");

   a_none_no_code: assert property (@(posedge clock) disable iff (reset)
      step && result.press_kind == KIND_NONE |-> result.key_code == '0)
      else $error("A transaction without a press carries a key code.");

   a_short_enters_pressed: assert property (@(posedge clock) disable iff (reset)
      step && result.press_kind == KIND_SHORT |=> mode_ff == MODE_PRESSED)
      else $error("A short press did not move the detector to the pressed state.");

   a_held_key_valid: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_IDLE |-> $onehot(held_code_ff))
      else $error("Detector holds a key without a single valid key code.");

   a_lockout_only_from_pressed: assert property (@(posedge clock) disable iff (reset)
      step && !lockout_pending_ff && lockout_pending_in |-> mode_ff == MODE_PRESSED)
      else $error("Release lockout armed outside the pressed state.");

endmodule

// ----- hdl/keypad_press_repeat_accel.sv -----
// Top level of the keypad press detector with accelerating auto-repeat.
//
//   channel   | direction | contents
//   req_chan  | in        | now_ticks, key_bits (one poll per transaction)
//   rsp_chan  | out       | key_code, press_kind (one result per poll)
//   csr_*     | in        | write enable, register index, 16-bit write data
//
// One poll is accepted per cycle while results are taken; its result is offered
// from the output register. The poll sits in an input register, then the detector
// state and result register update together in the same cycle.
// A stalled result holds the output register; one further poll waits in the input
// register, after which req_chan.ready drops.
// Reset is synchronous and returns the detector to idle with reset register values.
module keypad_press_repeat_accel import kpra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   kpra_req_if.sink           req_chan,
   kpra_rsp_if.source         rsp_chan,
   input  logic               csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  cfg_word_type       csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   tick_type   in_now_ff;
   code_type   in_keys_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       step;

   assign step           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.release_lockout       <= RST_RELEASE_LOCKOUT;
         cfg_ff.hold_before_repeat    <= RST_HOLD_BEFORE_REP;
         cfg_ff.repeat_start_interval <= RST_REP_START;
         cfg_ff.repeat_floor_interval <= RST_REP_FLOOR;
         cfg_ff.speedup_period        <= RST_SPEEDUP_PERIOD;
         cfg_ff.speedup_amount        <= RST_SPEEDUP_AMOUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RELEASE_LOCKOUT: cfg_ff.release_lockout       <= csr_wdata;
            CSR_HOLD_BEFORE_REP: cfg_ff.hold_before_repeat    <= csr_wdata;
            CSR_REP_START:       cfg_ff.repeat_start_interval <= csr_wdata;
            CSR_REP_FLOOR:       cfg_ff.repeat_floor_interval <= csr_wdata;
            CSR_SPEEDUP_PERIOD:  cfg_ff.speedup_period        <= csr_wdata;
            CSR_SPEEDUP_AMOUNT:  cfg_ff.speedup_amount        <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_now_ff  <= req_chan.now_ticks;
         in_keys_ff <= req_chan.key_bits;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   kpra_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .now_ticks (in_now_ff),
      .key_bits  (in_keys_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.key_code   = out_ff.key_code;
   assign rsp_chan.press_kind = out_ff.press_kind;

endmodule

// ----- tb/sv/tb_keypad_press_repeat_accel.sv -----
// Self-checking testbench of the keypad press detector with accelerating auto-repeat.
module tb_keypad_press_repeat_accel;
   import kpra_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD_AT  = 300;
   localparam int LONG_HOLD_LEN = 150;
   localparam int MAX_REPORTS   = 50;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_PRESSED = 2'd1,
      ST_REPEAT  = 2'd2
   } det_mode_type;

   typedef struct packed {
      tick_type now_ticks;
      code_type key_bits;
   } poll_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   cfg_word_type         csr_wdata;

   kpra_req_if req_chan();
   kpra_rsp_if rsp_chan();

   keypad_press_repeat_accel dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   poll_type     pending_polls[$];
   result_type   expected_reports[$];
   tick_type     stim_tick;
   int           stim_added;
   bit           calm;
   int           mismatches = 0;
   int           reports_seen = 0;
   int           quiet_cycles = 0;

   cfg_type      regs_now;
   det_mode_type det_mode;
   code_type     det_code;
   tick_type     press_at;
   tick_type     repeat_at;
   tick_type     release_at;
   cfg_word_type cur_interval;
   bit           lockout_armed;

   function automatic void clear_detector();
      det_mode      = ST_IDLE;
      det_code      = '0;
      press_at      = '0;
      repeat_at     = '0;
      release_at    = '0;
      cur_interval  = '0;
      lockout_armed = 1'b0;
   endfunction

   function automatic code_type lone_key(input code_type bits);
      if ((bits & (bits - code_type'(1))) != '0)
         return '0;
      return bits;
   endfunction

   // Advances the detector by one poll and returns what it reports.
   function automatic result_type poll_outcome(input tick_type now, input code_type bits);
      result_type r;
      code_type   key;
      key          = lone_key(bits);
      r.key_code   = '0;
      r.press_kind = KIND_NONE;
      case (det_mode)
         ST_PRESSED: begin
            if (key != det_code) begin
               det_mode      = ST_IDLE;
               release_at    = now;
               lockout_armed = 1'b1;
            end else if (tick_type'(now - press_at) >= tick_type'(regs_now.hold_before_repeat)) begin
               press_at     = now;
               repeat_at    = now;
               cur_interval = regs_now.repeat_start_interval;
               det_mode     = ST_REPEAT;
               r.key_code   = key;
               r.press_kind = KIND_LONG;
            end
         end
         ST_REPEAT: begin
            if (key != det_code) begin
               det_mode = ST_IDLE;
            end else if (tick_type'(now - repeat_at) >= tick_type'(cur_interval)) begin
               repeat_at    = now;
               r.key_code   = key;
               r.press_kind = KIND_LONG;
            end else if (cur_interval > regs_now.repeat_floor_interval &&
                         tick_type'(now - press_at) >= tick_type'(regs_now.speedup_period)) begin
               cur_interval = (cur_interval > regs_now.speedup_amount) ?
                              cfg_word_type'(cur_interval - regs_now.speedup_amount) : '0;
               press_at     = now;
            end
         end
         default: begin
            det_mode = ST_IDLE;
            if (!(lockout_armed &&
                  tick_type'(now - release_at) < tick_type'(regs_now.release_lockout))) begin
               lockout_armed = 1'b0;
               if (key != '0) begin
                  det_mode     = ST_PRESSED;
                  press_at     = now;
                  det_code     = key;
                  r.key_code   = key;
                  r.press_kind = KIND_SHORT;
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      if (mismatches < MAX_REPORTS)
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endfunction

   // Poll driver: offers queued polls and predicts each accepted transaction.
   int gap_left;
   always @(posedge clock) begin
      poll_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
         clear_detector();
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_reports.push_back(poll_outcome(req_chan.now_ticks, req_chan.key_bits));
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left == 0 && !calm && $urandom_range(0, 7) == 0)
               gap_left = $urandom_range(1, 11);
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_polls.size() > 0) begin
               nxt = pending_polls.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.now_ticks <= nxt.now_ticks;
               req_chan.key_bits  <= nxt.key_bits;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transaction and paces ready.
   int stall_left;
   int long_hold_left;
   bit long_hold_done;
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     = 0;
         long_hold_left = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("%0t ns: unexpected result, expected none, actual key_code %0d kind %0d",
                           $time, rsp_chan.key_code, int'(rsp_chan.press_kind));
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_chan.key_code !== want.key_code)
                  note_mismatch("key_code", int'(want.key_code), int'(rsp_chan.key_code));
               if (rsp_chan.press_kind !== want.press_kind)
                  note_mismatch("press_kind", int'(want.press_kind), int'(rsp_chan.press_kind));
            end
         end
         if (!long_hold_done && reports_seen >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_LEN;
         end
         if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_at(input tick_type t, input code_type bits);
      poll_type p;
      stim_tick   = t;
      p.now_ticks = t;
      p.key_bits  = bits;
      pending_polls.push_back(p);
      stim_added++;
   endtask

   task automatic add_poll(input code_type bits, input int step_max);
      add_at(stim_tick + tick_type'($urandom_range(0, step_max)), bits);
   endtask

   function automatic code_type one_key();
      return code_type'(1) << $urandom_range(0, KEY_BITS - 1);
   endfunction

   function automatic code_type several_keys();
      int a;
      int b;
      a = $urandom_range(0, KEY_BITS - 1);
      b = (a + 1 + $urandom_range(0, KEY_BITS - 2)) % KEY_BITS;
      return (code_type'(1) << a) | (code_type'(1) << b) | code_type'($urandom_range(0, 63));
   endfunction

   // A press, a hold of random length with rare glitches, then some kind of release.
   task automatic add_session(input int step_max, input int hold_max);
      code_type key;
      int       n_hold;
      int       n_idle;
      key    = one_key();
      n_hold = $urandom_range(0, hold_max);
      n_idle = $urandom_range(0, 3);
      add_poll(key, step_max);
      repeat (n_hold) begin
         if ($urandom_range(0, 19) == 0)
            add_poll(code_type'($urandom_range(0, 63)), step_max);
         else
            add_poll(key, step_max);
      end
      case ($urandom_range(0, 3))
         0: add_poll(several_keys(), step_max);
         1: add_poll(one_key(), step_max);
         default: add_poll('0, step_max);
      endcase
      repeat (n_idle) add_poll('0, step_max);
   endtask

   task automatic add_noise(input int step_max);
      int n;
      n = $urandom_range(1, 5);
      repeat (n) begin
         if ($urandom_range(0, 1) == 0)
            stim_tick = $urandom;
         add_poll(code_type'($urandom_range(0, 63)), step_max);
      end
   endtask

   task automatic gen_polls(input int n, input int step_max, input int hold_max);
      int goal;
      goal = stim_added + n;
      while (stim_added < goal) begin
         if ($urandom_range(0, 7) == 0)
            add_noise(step_max);
         else
            add_session(step_max, hold_max);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_polls.size() != 0 || req_chan.valid || expected_reports.size() != 0);
   endtask

   task automatic write_reg(input csr_idx_type idx, input cfg_word_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_RELEASE_LOCKOUT: regs_now.release_lockout       = val;
         CSR_HOLD_BEFORE_REP: regs_now.hold_before_repeat    = val;
         CSR_REP_START:       regs_now.repeat_start_interval = val;
         CSR_REP_FLOOR:       regs_now.repeat_floor_interval = val;
         CSR_SPEEDUP_PERIOD:  regs_now.speedup_period        = val;
         CSR_SPEEDUP_AMOUNT:  regs_now.speedup_amount        = val;
         default: ;
      endcase
   endtask

   // Waits for the block to go idle, reprograms every register, then queues polls.
   task automatic run_phase(input cfg_word_type lockout, input cfg_word_type hold,
                            input cfg_word_type start, input cfg_word_type floor_iv,
                            input cfg_word_type period, input cfg_word_type amount,
                            input bit quiet, input int n, input int step_max,
                            input int hold_max);
      wait_drained();
      repeat (4) @(posedge clock);
      write_reg(CSR_RELEASE_LOCKOUT, lockout);
      write_reg(CSR_HOLD_BEFORE_REP, hold);
      write_reg(CSR_REP_START, start);
      write_reg(CSR_REP_FLOOR, floor_iv);
      write_reg(CSR_SPEEDUP_PERIOD, period);
      write_reg(CSR_SPEEDUP_AMOUNT, amount);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      calm = quiet;
      gen_polls(n, step_max, hold_max);
   endtask

   initial begin
      csr_we             = 1'b0;
      csr_index          = CSR_RELEASE_LOCKOUT;
      csr_wdata          = '0;
      calm               = 1'b0;
      stim_tick          = '0;
      stim_added         = 0;
      regs_now.release_lockout       = RST_RELEASE_LOCKOUT;
      regs_now.hold_before_repeat    = RST_HOLD_BEFORE_REP;
      regs_now.repeat_start_interval = RST_REP_START;
      regs_now.repeat_floor_interval = RST_REP_FLOOR;
      regs_now.speedup_period        = RST_SPEEDUP_PERIOD;
      regs_now.speedup_amount        = RST_SPEEDUP_AMOUNT;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed polls under the reset register values: press, hold, repeat,
      // speed-up, release from both states, lockout and tick wrap-around.
      add_at(32'd0,          6'b000000);
      add_at(32'd5,          6'b000011);
      add_at(32'd10,         6'b000001);
      add_at(32'd600,        6'b000001);
      add_at(32'd700,        6'b000001);
      add_at(32'd1100,       6'b000001);
      add_at(32'd1200,       6'b000001);
      add_at(32'd1210,       6'b000000);
      add_at(32'd1220,       6'b100000);
      add_at(32'd1230,       6'b111111);
      add_at(32'd1300,       6'b001000);
      add_at(32'd1430,       6'b001000);
      add_at(32'd1440,       6'b000000);
      add_at(32'hFFFF_FF00,  6'b010000);
      add_at(32'hFFFF_FFFF,  6'b010000);
      add_at(32'h0000_0100,  6'b010000);
      add_at(32'h0000_0200,  6'b000100);
      add_at(32'h0000_0300,  6'b000100);
      add_at(32'h0000_0301,  6'b000010);
      add_at(32'hFFFF_FFFF,  6'b000010);
      add_at(32'hFFFF_FFFF,  6'b000010);

      gen_polls(200, 60, 60);
      run_phase(16'd30, 16'd20, 16'd30, 16'd5, 16'd15, 16'd7, 1'b0, 200, 8, 60);
      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 150, 3, 20);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 150, 30000, 8);
      run_phase(16'd5, 16'd10, 16'd40, 16'd0, 16'd3, 16'd100, 1'b0, 150, 6, 40);
      run_phase(cfg_word_type'($urandom_range(0, 120)), cfg_word_type'($urandom_range(0, 120)),
                cfg_word_type'($urandom_range(0, 120)), cfg_word_type'($urandom_range(0, 120)),
                cfg_word_type'($urandom_range(0, 120)), cfg_word_type'($urandom_range(0, 120)),
                1'b1, 150, 20, 40);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
